/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* rtl/i4dq_pkg.sv */
package i4dq_pkg;

   localparam int ACT_W   = 16;
   localparam int SCALE_W = 16;
   localparam int ZERO_W  = 16;
   localparam int NIB_W   = 4;
   localparam int ZERO_FRAC = 10;
   localparam int D_W     = 17;
   localparam int PROD_W  = D_W + SCALE_W;
   localparam int TERM_W  = PROD_W + ACT_W;

   typedef struct packed {
      logic signed [D_W-1:0]     d_even;
      logic signed [D_W-1:0]     d_odd;
      logic signed [SCALE_W-1:0] scale;
      logic signed [ACT_W-1:0]   act_even;
      logic signed [ACT_W-1:0]   act_odd;
      logic                      last;
   } i4dq_item_type;

endpackage

/* rtl/i4dq_front.sv */
`include "assert_macros.svh"

module i4dq_front
   import i4dq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [ACT_W-1:0]   req_act_even,
   input  logic signed [ACT_W-1:0]   req_act_odd,
   input  logic [7:0]                req_weight_byte,
   input  logic signed [SCALE_W-1:0] req_group_scale,
   input  logic signed [ZERO_W-1:0]  req_group_zero,
   input  logic                      req_last_of_dot,
   output logic                      out_valid,
   output i4dq_item_type             out_item,
   input  logic                      out_ready
);

   logic          front_valid_ff;
   i4dq_item_type front_item_ff;
   i4dq_item_type front_item_in;
   logic [NIB_W-1:0] nib_even;
   logic [NIB_W-1:0] nib_odd;
   logic signed [D_W-1:0] zero_ext;

   assign req_ready = !front_valid_ff || out_ready;
   assign out_valid = front_valid_ff;
   assign out_item  = front_item_ff;

   // nibble sign-extended and lifted to q7.10, minus the zero point
   always_comb begin
      nib_even = req_weight_byte[NIB_W-1:0];
      nib_odd  = req_weight_byte[2*NIB_W-1:NIB_W];
      zero_ext = {req_group_zero[ZERO_W-1], req_group_zero};
      front_item_in.d_even   = {{(D_W-NIB_W-ZERO_FRAC){nib_even[NIB_W-1]}}, nib_even,
                                {ZERO_FRAC{1'b0}}} - zero_ext;
      front_item_in.d_odd    = {{(D_W-NIB_W-ZERO_FRAC){nib_odd[NIB_W-1]}}, nib_odd,
                                {ZERO_FRAC{1'b0}}} - zero_ext;
      front_item_in.scale    = req_group_scale;
      front_item_in.act_even = req_act_even;
      front_item_in.act_odd  = req_act_odd;
      front_item_in.last     = req_last_of_dot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            front_valid_ff <= 1'b1;
            front_item_ff  <= front_item_in;
         end else if (out_ready) begin
            front_valid_ff <= 1'b0;
         end
      end
   end

   `ASSERT_CLK(a_front_hold, clock, reset, front_valid_ff && !out_ready |=> front_valid_ff && $stable(front_item_ff))

endmodule

/* rtl/i4dq_queue.sv */
`include "assert_macros.svh"

module i4dq_queue
   import i4dq_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  i4dq_item_type push_item,
   output logic          push_ready,
   input  logic          pop,
   output logic          pop_valid,
   output i4dq_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i4dq_item_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entries_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `ASSERT_NEVER(a_queue_over, clock, reset, count_ff > CNT_W'(DEPTH))

endmodule

/* rtl/i4dq_back.sv */
`include "assert_macros.svh"

module i4dq_back
   import i4dq_pkg::*;
#(
   parameter int ACC_WIDTH = 56
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  i4dq_item_type        q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ACC_WIDTH-1:0] rsp_dot_value,
   output logic                 rsp_saturated
);

   localparam int SUM_W = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;
   localparam logic signed [SUM_W-1:0] ACC_MAX =
      {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN =
      {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MUL_ACT,
      ST_ADD_EVEN,
      ST_ADD_ODD
   } state_type;

   state_type                   state_ff;
   logic signed [PROD_W-1:0]    prod_even_ff;
   logic signed [PROD_W-1:0]    prod_odd_ff;
   logic signed [ACT_W-1:0]     act_even_ff;
   logic signed [ACT_W-1:0]     act_odd_ff;
   logic                        last_ff;
   logic signed [TERM_W-1:0]    term_even_ff;
   logic signed [TERM_W-1:0]    term_odd_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic                        clip_ff;
   logic                        rsp_valid_ff;
   logic [ACC_WIDTH-1:0]        rsp_dot_ff;
   logic                        rsp_sat_ff;

   logic signed [TERM_W-1:0]    term_sel;
   logic signed [SUM_W-1:0]     acc_ext;
   logic signed [SUM_W-1:0]     term_ext;
   logic signed [SUM_W-1:0]     sum;
   logic signed [SUM_W-1:0]     sum_clamped;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic                        clamp_hit;
   logic                        out_free;
   logic                        emit;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dot_value = rsp_dot_ff;
   assign rsp_saturated = rsp_sat_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_LOAD) && q_valid;
   assign emit     = (state_ff == ST_ADD_ODD) && last_ff && out_free;

   // one saturating adder shared by the even and odd terms
   always_comb begin
      term_sel = (state_ff == ST_ADD_ODD) ? term_odd_ff : term_even_ff;
      acc_ext  = {{(SUM_W-ACC_WIDTH){acc_ff[ACC_WIDTH-1]}}, acc_ff};
      term_ext = {{(SUM_W-TERM_W){term_sel[TERM_W-1]}}, term_sel};
      sum      = acc_ext + term_ext;
      if (sum > ACC_MAX) begin
         sum_clamped = ACC_MAX;
         clamp_hit   = 1'b1;
      end else if (sum < ACC_MIN) begin
         sum_clamped = ACC_MIN;
         clamp_hit   = 1'b1;
      end else begin
         sum_clamped = sum;
         clamp_hit   = 1'b0;
      end
      acc_in = sum_clamped[ACC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (q_valid) begin
                  prod_even_ff <= $signed(q_item.d_even) * $signed(q_item.scale);
                  prod_odd_ff  <= $signed(q_item.d_odd) * $signed(q_item.scale);
                  act_even_ff  <= q_item.act_even;
                  act_odd_ff   <= q_item.act_odd;
                  last_ff      <= q_item.last;
                  state_ff     <= ST_MUL_ACT;
               end
            end
            ST_MUL_ACT: begin
               term_even_ff <= prod_even_ff * act_even_ff;
               term_odd_ff  <= prod_odd_ff * act_odd_ff;
               state_ff     <= ST_ADD_EVEN;
            end
            ST_ADD_EVEN: begin
               acc_ff   <= acc_in;
               clip_ff  <= clip_ff || clamp_hit;
               state_ff <= ST_ADD_ODD;
            end
            ST_ADD_ODD: begin
               if (!last_ff) begin
                  acc_ff   <= acc_in;
                  clip_ff  <= clip_ff || clamp_hit;
                  state_ff <= ST_LOAD;
               end else if (out_free) begin
                  rsp_dot_ff   <= acc_in;
                  rsp_sat_ff   <= clip_ff || clamp_hit;
                  acc_ff       <= '0;
                  clip_ff      <= 1'b0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   `ASSERT_CLK(a_back_order, clock, reset, state_ff == ST_MUL_ACT |-> $past(state_ff) == ST_LOAD)
   `ASSERT_CLK(a_emit_clears, clock, reset, emit |=> (acc_ff == '0) && !clip_ff && rsp_valid_ff)

endmodule

/* rtl/int4_group_dequant_dot.sv */
// channel  direction  transfer condition        contents
// req      in         req_valid & req_ready     two activations, weight byte, scale, zero, last
// rsp      out        rsp_valid & rsp_ready     dot value and clip flag, one per last item
//
// the front takes an item every cycle while the queue of QUEUE_DEPTH entries has room
// the back takes each item through a scale multiply, an activation multiply,
// then even and odd saturating adds through one shared adder
// and pops no new item from the queue until the odd add of the last one is done
// reset is synchronous and clears accumulator, clip flag, queue and the valid flag of the result register
// a held result stalls the back on the odd add of the next last item only

module int4_group_dequant_dot
   import i4dq_pkg::*;
#(
   parameter int ACC_WIDTH   = 56,
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [ACT_W-1:0]   req_act_even,
   input  logic signed [ACT_W-1:0]   req_act_odd,
   input  logic [7:0]                req_weight_byte,
   input  logic signed [SCALE_W-1:0] req_group_scale,
   input  logic signed [ZERO_W-1:0]  req_group_zero,
   input  logic                      req_last_of_dot,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ACC_WIDTH-1:0]      rsp_dot_value,
   output logic                      rsp_saturated
);

   logic          front_valid;
   i4dq_item_type front_item;
   logic          front_ready;
   logic          queue_valid;
   i4dq_item_type queue_item;
   logic          queue_pop;

   i4dq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_act_even    (req_act_even),
      .req_act_odd     (req_act_odd),
      .req_weight_byte (req_weight_byte),
      .req_group_scale (req_group_scale),
      .req_group_zero  (req_group_zero),
      .req_last_of_dot (req_last_of_dot),
      .out_valid       (front_valid),
      .out_item        (front_item),
      .out_ready       (front_ready)
   );

   i4dq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (front_ready),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item)
   );

   i4dq_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (queue_valid),
      .q_item        (queue_item),
      .q_pop         (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dot_value (rsp_dot_value),
      .rsp_saturated (rsp_saturated)
   );

endmodule
